[src/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, the divider stage word and helpers for the ray/triangle
// intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

  // coordinate width, signed q16.16
  localparam int CW = 32;
  // wide exact values: determinant and the three numerators
  localparam int WW = 104;
  // quotient bits produced by the divider
  localparam int QB = 33;
  // remainder width of the divider, holds det shifted by QB-1
  localparam int WR = WW + QB - 1;
  // register stages ahead of the divider
  localparam int FRONT_STAGES = 12;
  // chunk width used to split det for the near-limit product
  localparam int CHK = 26;

  // configuration register indexes
  typedef enum logic [3:0] {
    CFG_ORG_X = 4'd0,
    CFG_ORG_Y = 4'd1,
    CFG_ORG_Z = 4'd2,
    CFG_DIR_X = 4'd3,
    CFG_DIR_Y = 4'd4,
    CFG_DIR_Z = 4'd5,
    CFG_NEAR  = 4'd6,
    CFG_FAR   = 4'd7
  } rti_cfg_t;

  // one word moving through the divider stages
  typedef struct packed {
    logic [WR-1:0] rem;
    logic [WW-1:0] det;
    logic [QB-1:0] quo;
    logic          ok;
  } rti_div_t;

  // signed 34 x 34 multiply, exact 68-bit product
  function automatic logic signed [67:0] mul_s(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    mul_s = a * b;
  endfunction

endpackage

`default_nettype wire

[src/rti_div.sv]
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit per stage, with a
// bubble-collapsing valid/ready chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_div
  import rti_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_vld,
  output logic          in_rdy,
  input  wire rti_div_t in_word,
  output logic          out_vld,
  input  wire logic     out_rdy,
  output rti_div_t      out_word
);

  rti_div_t        st_r [QB];
  logic [QB-1:0]   vld_r;
  logic [QB-1:0]   en;

  // stage k may load when it is empty or its successor loads
  always_comb begin
    en[QB-1] = !vld_r[QB-1] || out_rdy;
    for (int k = QB - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  genvar g;
  generate
    for (g = 0; g < QB; g++) begin : g_stage
      localparam int SH = QB - 1 - g;
      rti_div_t     src;
      logic         src_vld;
      logic [WR:0]  trial;
      rti_div_t     nxt;

      if (g == 0) begin : g_first
        assign src     = in_word;
        assign src_vld = in_vld;
      end else begin : g_next
        assign src     = st_r[g-1];
        assign src_vld = vld_r[g-1];
      end

      // try subtracting det shifted to this quotient bit
      always_comb begin
        trial = {1'b0, src.rem} - ({1'b0, WR'(src.det)} << SH);
        nxt   = src;
        nxt.quo = {src.quo[QB-2:0], !trial[WR]};
        if (!trial[WR]) begin
          nxt.rem = trial[WR-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (en[g]) begin
          vld_r[g] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en[g]) begin
          st_r[g] <= nxt;
        end
      end
    end
  endgenerate

  assign in_rdy   = en[0];
  assign out_vld  = vld_r[QB-1];
  assign out_word = st_r[QB-1];

endmodule

`default_nettype wire

[src/ray_triangle_intersect_top.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Ray/triangle intersection by Cramer's rule in exact fixed point.
// ----------------------------------------------------------------------------
// Takes one triangle word per cycle while the output is not stalled and
// gives one result word per triangle, in order: 12 stages form the exact
// determinant and numerators (cross products, split wide products, sign
// normalization, near-limit product), 33 stages of a restoring divider
// produce the distance one bit each, and one stage applies the far limit
// and registers the result. Each stage holds its word when the stage after
// it is full, so empty stages close up under a stall. The user must write the
// ray and the distance window on the cfg port only while no triangle is in
// flight; the block does not enforce this. Index values above 7 are ignored.
`default_nettype none

module ray_triangle_intersect_top
  import rti_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 32 bits each from bit 0
  input  wire logic [287:0]  in_tdata,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // hit_distance [31:0]
  output logic [31:0]        out_tdata,
  // hit [0]
  output logic               out_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [3:0]    cfg_addr,
  input  wire logic [31:0]   cfg_data
);

  // configuration registers
  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic signed [CW-1:0] near_r;
  logic signed [CW-1:0] far_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
      near_r <= '0;
      far_r  <= 32'sh7FFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_ORG_X: org_r[0] <= cfg_data;
        CFG_ORG_Y: org_r[1] <= cfg_data;
        CFG_ORG_Z: org_r[2] <= cfg_data;
        CFG_DIR_X: dir_r[0] <= cfg_data;
        CFG_DIR_Y: dir_r[1] <= cfg_data;
        CFG_DIR_Z: dir_r[2] <= cfg_data;
        CFG_NEAR:  near_r   <= cfg_data;
        CFG_FAR:   far_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake chain
  logic [FRONT_STAGES-1:0] vld_r;
  logic [FRONT_STAGES-1:0] en;
  logic                    div_in_rdy;

  always_comb begin
    en[FRONT_STAGES-1] = !vld_r[FRONT_STAGES-1] || div_in_rdy;
    for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // input fields
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = in_tdata[CW*i +: CW];
      vb[i] = in_tdata[CW*(i+3) +: CW];
      vc[i] = in_tdata[CW*(i+6) +: CW];
    end
  end

  // stage data
  logic signed [32:0]  e1_1_r [3], e2_1_r [3], s_1_r [3];
  logic signed [32:0]  e1_2_r [3], e2_2_r [3], s_2_r [3];
  logic signed [64:0]  mp_2_r [6];
  logic signed [65:0]  np_2_r [6];
  logic signed [32:0]  e1_3_r [3], e2_3_r [3], s_3_r [3];
  logic signed [65:0]  m_3_r [3];
  logic signed [66:0]  n_3_r [3];
  logic signed [67:0]  dh_4_r [3], dl_4_r [3], bh_4_r [3], bl_4_r [3];
  logic signed [67:0]  th_4_r [3], tl_4_r [3], gh_4_r [3], gl_4_r [3];
  logic signed [WW-1:0] dt_5_r [3], bt_5_r [3], tt_5_r [3], gt_5_r [3];
  logic signed [WW-1:0] ds_6_r, bs_6_r, ts_6_r, gs_6_r;
  logic signed [WW-1:0] det_7_r, tn_7_r, bn_7_r, gn_7_r;
  logic                 nz_7_r;
  logic signed [WW-1:0] det_8_r, bg_8_r;
  logic signed [WR-1:0] scl_8_r;
  logic signed [67:0]   pp_8_r [4];
  logic                 ok_8_r;
  logic signed [WW-1:0] det_9_r;
  logic signed [WR-1:0] scl_9_r, q01_9_r, q23_9_r;
  logic                 ok_9_r;
  logic signed [WW-1:0] det_10_r;
  logic signed [WR-1:0] scl_10_r, nd_10_r;
  logic                 ok_10_r;
  logic signed [WW-1:0] det_11_r;
  logic signed [WR-1:0] r_11_r;
  logic                 ok_11_r;
  rti_div_t             dw_12_r;

  // normalization helpers for stage 7
  logic                 det_neg;
  assign det_neg = ds_6_r[WW-1];

  always_ff @(posedge clk) begin
    // edge vectors and origin offset
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        e1_1_r[i] <= $signed({va[i][CW-1], va[i]}) - $signed({vb[i][CW-1], vb[i]});
        e2_1_r[i] <= $signed({va[i][CW-1], va[i]}) - $signed({vc[i][CW-1], vc[i]});
        s_1_r[i]  <= $signed({va[i][CW-1], va[i]}) - $signed({org_r[i][CW-1], org_r[i]});
      end
    end
    // cross product terms
    if (en[1]) begin
      e1_2_r <= e1_1_r;
      e2_2_r <= e2_1_r;
      s_2_r  <= s_1_r;
      mp_2_r[0] <= e2_1_r[1] * dir_r[2];
      mp_2_r[1] <= dir_r[1] * e2_1_r[2];
      mp_2_r[2] <= dir_r[0] * e2_1_r[2];
      mp_2_r[3] <= e2_1_r[0] * dir_r[2];
      mp_2_r[4] <= e2_1_r[0] * dir_r[1];
      mp_2_r[5] <= e2_1_r[1] * dir_r[0];
      np_2_r[0] <= e1_1_r[0] * s_1_r[1];
      np_2_r[1] <= s_1_r[0] * e1_1_r[1];
      np_2_r[2] <= s_1_r[0] * e1_1_r[2];
      np_2_r[3] <= e1_1_r[0] * s_1_r[2];
      np_2_r[4] <= e1_1_r[1] * s_1_r[2];
      np_2_r[5] <= s_1_r[1] * e1_1_r[2];
    end
    // cross products
    if (en[2]) begin
      e1_3_r <= e1_2_r;
      e2_3_r <= e2_2_r;
      s_3_r  <= s_2_r;
      for (int i = 0; i < 3; i++) begin
        m_3_r[i] <= 66'(mp_2_r[2*i]) - 66'(mp_2_r[2*i+1]);
        n_3_r[i] <= 67'(np_2_r[2*i]) - 67'(np_2_r[2*i+1]);
      end
    end
    // split partial products of the dot products
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        dh_4_r[i] <= mul_s(34'(e1_3_r[i]), 34'($signed(m_3_r[i][65:33])));
        dl_4_r[i] <= mul_s(34'(e1_3_r[i]), $signed({1'b0, m_3_r[i][32:0]}));
        bh_4_r[i] <= mul_s(34'(s_3_r[i]), 34'($signed(m_3_r[i][65:33])));
        bl_4_r[i] <= mul_s(34'(s_3_r[i]), $signed({1'b0, m_3_r[i][32:0]}));
        th_4_r[i] <= mul_s(34'(e2_3_r[2-i]), $signed(n_3_r[i][66:33]));
        tl_4_r[i] <= mul_s(34'(e2_3_r[2-i]), $signed({1'b0, n_3_r[i][32:0]}));
        gh_4_r[i] <= mul_s(34'(dir_r[2-i]), $signed(n_3_r[i][66:33]));
        gl_4_r[i] <= mul_s(34'(dir_r[2-i]), $signed({1'b0, n_3_r[i][32:0]}));
      end
    end
    // recombine the halves
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        dt_5_r[i] <= (WW'(dh_4_r[i]) <<< 33) + WW'(dl_4_r[i]);
        bt_5_r[i] <= (WW'(bh_4_r[i]) <<< 33) + WW'(bl_4_r[i]);
        tt_5_r[i] <= (WW'(th_4_r[i]) <<< 33) + WW'(tl_4_r[i]);
        gt_5_r[i] <= (WW'(gh_4_r[i]) <<< 33) + WW'(gl_4_r[i]);
      end
    end
    // dot product sums
    if (en[5]) begin
      ds_6_r <= dt_5_r[0] + dt_5_r[1] + dt_5_r[2];
      bs_6_r <= bt_5_r[0] + bt_5_r[1] + bt_5_r[2];
      ts_6_r <= tt_5_r[0] + tt_5_r[1] + tt_5_r[2];
      gs_6_r <= gt_5_r[0] + gt_5_r[1] + gt_5_r[2];
    end
    // make det positive; the t numerator carries its own negation
    if (en[6]) begin
      det_7_r <= det_neg ? -ds_6_r : ds_6_r;
      tn_7_r  <= det_neg ? ts_6_r : -ts_6_r;
      bn_7_r  <= det_neg ? -bs_6_r : bs_6_r;
      gn_7_r  <= det_neg ? -gs_6_r : gs_6_r;
      nz_7_r  <= (ds_6_r != '0);
    end
    // barycentric sign tests and near-limit partial products
    if (en[7]) begin
      det_8_r <= det_7_r;
      bg_8_r  <= bn_7_r + gn_7_r;
      scl_8_r <= WR'(tn_7_r) <<< 16;
      ok_8_r  <= nz_7_r && !bn_7_r[WW-1] && !gn_7_r[WW-1] && (gn_7_r <= det_7_r);
      for (int j = 0; j < 4; j++) begin
        pp_8_r[j] <= mul_s(34'(near_r), $signed(34'(det_7_r[CHK*j +: CHK])));
      end
    end
    // edge sum test and first partial sums
    if (en[8]) begin
      det_9_r <= det_8_r;
      scl_9_r <= scl_8_r;
      ok_9_r  <= ok_8_r && (bg_8_r <= det_8_r);
      q01_9_r <= WR'(pp_8_r[0]) + (WR'(pp_8_r[1]) <<< CHK);
      q23_9_r <= WR'(pp_8_r[2]) + (WR'(pp_8_r[3]) <<< CHK);
    end
    // near * det
    if (en[9]) begin
      det_10_r <= det_9_r;
      scl_10_r <= scl_9_r;
      ok_10_r  <= ok_9_r;
      nd_10_r  <= q01_9_r + (q23_9_r <<< (2 * CHK));
    end
    // offset from the near limit
    if (en[10]) begin
      det_11_r <= det_10_r;
      ok_11_r  <= ok_10_r;
      r_11_r   <= scl_10_r - nd_10_r;
    end
    // near test and quotient range check, load the divider word
    if (en[11]) begin
      dw_12_r.rem <= r_11_r;
      dw_12_r.det <= det_11_r;
      dw_12_r.quo <= '0;
      dw_12_r.ok  <= ok_11_r && !r_11_r[WR-1]
                     && (r_11_r < (WR'(det_11_r) <<< QB));
    end
  end

  // distance divider
  logic     div_out_vld;
  logic     fin_en;
  rti_div_t div_out;

  rti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r[FRONT_STAGES-1]),
    .in_rdy   (div_in_rdy),
    .in_word  (dw_12_r),
    .out_vld  (div_out_vld),
    .out_rdy  (fin_en),
    .out_word (div_out)
  );

  // far-limit test and result register
  logic signed [CW:0] span;
  logic               fin_hit;
  logic [CW-1:0]      fin_dist;
  logic               out_vld_r;
  logic               hit_r;
  logic [CW-1:0]      dist_r;

  assign fin_en = !out_vld_r || out_tready;

  always_comb begin
    span     = $signed({far_r[CW-1], far_r}) - $signed({near_r[CW-1], near_r});
    fin_hit  = div_out.ok && !span[CW]
               && ((div_out.quo < span[CW:0])
                   || ((div_out.quo == span[CW:0]) && (div_out.rem == '0)));
    fin_dist = fin_hit ? (near_r + div_out.quo[CW-1:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_en) begin
      out_vld_r <= div_out_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_en) begin
      hit_r  <= fin_hit;
      dist_r <= fin_dist;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = hit_r;
  assign out_tdata  = dist_r;

`ifndef ASSERT_OFF
  // a reported hit lies inside the distance window
  a_hit_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && hit_r |-> ($signed(dist_r) >= near_r) && ($signed(dist_r) <= far_r))
    else $error("hit distance outside window");

  // a miss reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !hit_r |-> dist_r == '0)
    else $error("miss with nonzero distance");

  // a full last front stage holds while the divider refuses it
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[FRONT_STAGES-1] && !div_in_rdy |=> vld_r[FRONT_STAGES-1])
    else $error("front word lost under stall");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_triangle_intersect_top. An exact wide-integer
// predictor of the Cramer's rule solver computes hit and distance for every
// accepted triangle word. Results are compared in order against that
// prediction, across several ray and window settings and handshake timings.
// ----------------------------------------------------------------------------
`default_nettype none

// expected result of one triangle
typedef struct {
  logic        hit;
  logic [31:0] distance;
} hit_word_t;

typedef logic signed [255:0] exact_t;

class ray_tri_board;
  logic [31:0] ray_regs[8];
  hit_word_t   pending[$];
  int          errors;

  function new();
    foreach (ray_regs[k]) ray_regs[k] = '0;
    ray_regs[rti_pkg::CFG_FAR] = 32'h7FFF_FFFF;
    errors = 0;
  endfunction

  function void write_reg(logic [3:0] idx, logic [31:0] val);
    if (idx < 8) ray_regs[idx] = val;
  endfunction

  function exact_t ext(logic signed [31:0] v);
    exact_t r;
    r = v;
    return r;
  endfunction

  // exact intersection: hit flag and floor of the distance in q16.16
  function hit_word_t predict(logic [287:0] tri_w);
    exact_t ax, ay, az, bx, by, bz, cx, cy, cz, nr, fr;
    exact_t e1x, e1y, e1z, e2x, e2y, e2z, dx, dy, dz, sx, sy, sz;
    exact_t m0, m1, m2, n0, n1, n2, det, tn, bn, gn, sc, q;
    hit_word_t r;
    ax = ext(tri_w[0+:32]);   ay = ext(tri_w[32+:32]);  az = ext(tri_w[64+:32]);
    bx = ext(tri_w[96+:32]);  by = ext(tri_w[128+:32]); bz = ext(tri_w[160+:32]);
    cx = ext(tri_w[192+:32]); cy = ext(tri_w[224+:32]); cz = ext(tri_w[256+:32]);
    dx = ext(ray_regs[rti_pkg::CFG_DIR_X]);
    dy = ext(ray_regs[rti_pkg::CFG_DIR_Y]);
    dz = ext(ray_regs[rti_pkg::CFG_DIR_Z]);
    nr = ext(ray_regs[rti_pkg::CFG_NEAR]);
    fr = ext(ray_regs[rti_pkg::CFG_FAR]);
    e1x = ax - bx; e1y = ay - by; e1z = az - bz;
    e2x = ax - cx; e2y = ay - cy; e2z = az - cz;
    sx = ax - ext(ray_regs[rti_pkg::CFG_ORG_X]);
    sy = ay - ext(ray_regs[rti_pkg::CFG_ORG_Y]);
    sz = az - ext(ray_regs[rti_pkg::CFG_ORG_Z]);
    m0 = e2y * dz - dy * e2z;
    m1 = dx * e2z - e2x * dz;
    m2 = e2x * dy - e2y * dx;
    n0 = e1x * sy - sx * e1y;
    n1 = sx * e1z - e1x * sz;
    n2 = e1y * sz - sy * e1z;
    det = e1x * m0 + e1y * m1 + e1z * m2;
    tn = -(e2z * n0 + e2y * n1 + e2x * n2);
    bn = sx * m0 + sy * m1 + sz * m2;
    gn = dz * n0 + dy * n1 + dx * n2;
    r.hit = 1'b0;
    r.distance = '0;
    // parallel ray or flat triangle
    if (det == 0) return r;
    if (det < 0) begin
      det = -det; tn = -tn; bn = -bn; gn = -gn;
    end
    sc = tn * 65536;
    if (sc < nr * det || sc > fr * det) return r;
    if (bn < 0 || gn < 0 || bn + gn > det || gn > det) return r;
    // floor division, det is positive here
    q = sc / det;
    if (sc < 0 && q * det != sc) q = q - 1;
    r.hit = 1'b1;
    r.distance = q[31:0];
    return r;
  endfunction

  function void note_triangle(logic [287:0] tri_w);
    pending.push_back(predict(tri_w));
  endfunction

  function void check_result(logic hit, logic [31:0] distance);
    hit_word_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word hit=%0b dist=%h", $time, hit, distance);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (hit !== e.hit) begin
      $display("%0t: hit mismatch expected %0b actual %0b", $time, e.hit, hit);
      errors++;
    end
    if (distance !== e.distance) begin
      $display("%0t: distance mismatch expected %h actual %h", $time, e.distance,
               distance);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam logic [3:0] CFG_UNUSED = 4'd12;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 5000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAX_V = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_V = 32'h8000_0000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [287:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  out_tdata;
  logic         out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_addr = '0;
  logic [31:0]  cfg_data = '0;

  ray_tri_board sb = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_len = 0;
  int quiet_cycles = 0;

  ray_triangle_intersect_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check words, random stalls and long hold-offs
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (hold_len > 0) begin
        hold_len--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // leaves cfg_valid high, caller lowers it after the batch
  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_addr <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                         logic [31:0] nr, logic [31:0] fr);
    write_reg(CFG_ORG_X, ox);
    write_reg(CFG_ORG_Y, oy);
    write_reg(CFG_ORG_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_NEAR, nr);
    write_reg(CFG_FAR, fr);
    // out-of-range index must leave the ray alone
    write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one triangle word, random idle afterwards
  task automatic send_tri(logic [287:0] w);
    in_tdata <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_triangle(w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sender pauses until every result is back, then lets the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [287:0] pack(logic [31:0] v[9]);
    logic [287:0] w;
    for (int k = 0; k < 9; k++) w[32*k +: 32] = v[k];
    return w;
  endfunction

  function automatic logic [31:0] fx(int whole);
    return 32'(whole) << 16;
  endfunction

  // triangle placed around a point on the ray, or a degenerate or noise word
  function automatic logic [287:0] rand_tri();
    logic [31:0] v[9];
    logic [63:0] t;
    int kind;
    kind = $urandom_range(99);
    t = $urandom_range(12);
    for (int k = 0; k < 9; k++) begin
      if (kind < 75)
        v[k] = sb.ray_regs[k % 3] + 32'(t * sb.ray_regs[3 + k % 3])
               + 32'($signed($urandom_range(1 << 19)) - (1 << 18));
      else
        v[k] = $urandom;
    end
    // collapsed vertex or full-range noise
    if (kind >= 75 && kind < 85) begin
      v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
    end
    return pack(v);
  endfunction

  function automatic logic [31:0] small_rand(int bits);
    return 32'($signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  task automatic set_idle(int mode);
    case (mode % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 71; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 71; end
      default: begin in_idle_pct = 25; out_stall_pct = 25; end
    endcase
  endtask

  initial begin
    logic [31:0] nr, fr;
    logic [31:0] v[9];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset ray has zero direction, every triangle misses
    for (int k = 0; k < 6; k++) send_tri(rand_tri());
    drain();

    // ray along +z from the origin, window 0..10
    set_ray(0, 0, 0, 0, 0, ONE, 0, fx(10));
    // through vertex a, through an edge, interior, behind, degenerate
    v = '{0, 0, fx(5), ONE, 0, fx(5), 0, ONE, fx(5)};              send_tri(pack(v));
    v = '{-ONE, 0, fx(3), ONE, 0, fx(3), 0, ONE, fx(3)};           send_tri(pack(v));
    v = '{-ONE, -ONE, fx(2), ONE, -ONE, fx(4), 0, ONE, fx(3)};     send_tri(pack(v));
    v = '{-ONE, -ONE, -fx(2), ONE, -ONE, -fx(2), 0, ONE, -fx(2)};  send_tri(pack(v));
    v = '{ONE, ONE, fx(4), ONE, ONE, fx(4), 0, ONE, fx(3)};        send_tri(pack(v));
    v = '{ONE, ONE, fx(4), fx(2), fx(2), fx(4), fx(3), fx(3), fx(4)}; send_tri(pack(v));
    v = '{-ONE, -ONE, fx(11), ONE, -ONE, fx(11), 0, ONE, fx(11)};  send_tri(pack(v));
    v = '{-ONE, -ONE, 32'h0003_5555, ONE, -ONE, 32'h0003_5555, 0, ONE, 32'h0003_5555};
    send_tri(pack(v));
    for (int k = 0; k < 9; k++) v[k] = MAX_V;
    send_tri(pack(v));
    for (int k = 0; k < 9; k++) v[k] = MIN_V;
    send_tri(pack(v));
    v = '{MIN_V, MIN_V, MAX_V, MAX_V, MIN_V, MAX_V, 0, MAX_V, MIN_V}; send_tri(pack(v));
    v = '{MAX_V, 0, MIN_V, MIN_V, MAX_V, 0, 0, MIN_V, MAX_V};         send_tri(pack(v));
    drain();

    // window closed to a single distance, then near above far
    set_ray(0, 0, 0, 0, 0, ONE, fx(5), fx(5));
    v = '{0, 0, fx(5), ONE, 0, fx(5), 0, ONE, fx(5)};              send_tri(pack(v));
    v = '{-ONE, -ONE, fx(5), ONE, -ONE, fx(5), 0, ONE, fx(5)};     send_tri(pack(v));
    v = '{-ONE, -ONE, fx(4), ONE, -ONE, fx(4), 0, ONE, fx(4)};     send_tri(pack(v));
    drain();
    set_ray(0, 0, 0, 0, 0, ONE, fx(6), fx(4));
    v = '{-ONE, -ONE, fx(5), ONE, -ONE, fx(5), 0, ONE, fx(5)};     send_tri(pack(v));
    drain();

    // extreme registers
    set_ray(MIN_V, MAX_V, MIN_V, MAX_V, MIN_V, MAX_V, MIN_V, MAX_V);
    for (int k = 0; k < 6; k++) send_tri(rand_tri());
    drain();

    // random rays and windows under every idling mode
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(3))
        0: nr = 0;
        1: nr = MIN_V;
        default: nr = small_rand(20);
      endcase
      fr = ($urandom_range(1)) ? MAX_V : nr + $urandom_range(32'h000F_FFFF);
      set_ray(small_rand(22), small_rand(22), small_rand(22),
              small_rand(18), small_rand(18), small_rand(18), nr, fr);
      set_idle(ph);
      // long receiver hold-off so the pipe fills and backs up
      if (ph == 4) hold_len = 400;
      for (int k = 0; k < 205; k++) send_tri(rand_tri());
      drain();
    end

    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

`default_nettype wire

[filelist.f]
src/rti_pkg.sv
src/rti_div.sv
src/ray_triangle_intersect_top.sv
verif/tb.sv
